// ----- rtl/hlfa_pkg.sv -----
// hlfa_pkg: shared types, codes and compare function for the hole list allocator
`timescale 1ns / 1ps
`default_nettype none
package hlfa_pkg;

   localparam int HLF_MAX_HOLES = 64;

   // fit policy codes
   localparam logic [1:0] POL_BEST  = 2'd0;
   localparam logic [1:0] POL_WORST = 2'd1;
   localparam logic [1:0] POL_ADDR  = 2'd2;
   localparam logic [1:0] POL_NONE  = 2'd3;

   // result status codes
   localparam logic [1:0] RSP_DONE = 2'd0;
   localparam logic [1:0] RSP_MISS = 2'd1;
   localparam logic [1:0] RSP_FULL = 2'd2;

   // request function codes
   localparam logic FUNC_RELEASE  = 1'b0;
   localparam logic FUNC_ALLOCATE = 1'b1;

   // datapath commands
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_IDLE      = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_APPEND    = 5'd2;
   localparam logic [OP_W-1:0] OP_SET_FULL  = 5'd3;
   localparam logic [OP_W-1:0] OP_SET_MISS  = 5'd4;
   localparam logic [OP_W-1:0] OP_SORT_INIT = 5'd5;
   localparam logic [OP_W-1:0] OP_SORT_CAR  = 5'd6;
   localparam logic [OP_W-1:0] OP_SORT_CMP  = 5'd7;
   localparam logic [OP_W-1:0] OP_SORT_LAST = 5'd8;
   localparam logic [OP_W-1:0] OP_MRG_INIT  = 5'd9;
   localparam logic [OP_W-1:0] OP_MRG_CAR   = 5'd10;
   localparam logic [OP_W-1:0] OP_MRG_CMP   = 5'd11;
   localparam logic [OP_W-1:0] OP_MRG_LAST  = 5'd12;
   localparam logic [OP_W-1:0] OP_ALC_INIT  = 5'd13;
   localparam logic [OP_W-1:0] OP_ALC_SCAN  = 5'd14;
   localparam logic [OP_W-1:0] OP_ALC_END   = 5'd15;
   localparam logic [OP_W-1:0] OP_SUM_INIT  = 5'd16;
   localparam logic [OP_W-1:0] OP_SUM_SCAN  = 5'd17;
   localparam logic [OP_W-1:0] OP_OUT       = 5'd18;

   typedef struct packed {
      logic        func;
      logic [31:0] block_offset;
      logic [23:0] block_size;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] grant_offset;
      logic [31:0] leftover_size;
      logic [6:0]  holes_now;
      logic [31:0] free_space;
   } rsp_word_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic func;
      logic full;
      logic cnt_zero;
      logic idx_one;
      logic idx_last;
      logic swapped;
      logic pol_sort;
      logic pol_merge;
   } dp_stat_type;

   // true when hole a must stand strictly before hole b
   function automatic logic precedes(input logic [1:0] pol,
                                     input logic [31:0] sa, input logic [31:0] oa,
                                     input logic [31:0] sb, input logic [31:0] ob);
      logic r;
      if (pol == POL_ADDR) begin
         r = (oa != ob) ? (oa < ob) : (sa < sb);
      end else if (sa != sb) begin
         r = (pol == POL_BEST) ? (sa < sb) : (sa > sb);
      end else begin
         r = oa < ob;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/hole_list_fit_allocator.sv -----
// hole_list_fit_allocator: top level joining the sequencer and the hole table datapath
// one word at a time: a dispatch step, then the work below, a sum scan and an output step
// release: backward sort passes until one makes no swap, plus the merge pass in address
//    order; allocate: fit scan and compaction
// the next word is taken once back in idle, even while the previous result waits on stall
// synchronous reset empties the table, clears the policy to best fit and the output valid
`timescale 1ns / 1ps
`default_nettype none
module hole_list_fit_allocator import hlfa_pkg::*; #(
   parameter int MAX_HOLES = HLF_MAX_HOLES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_wdata
);

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: one state per phase of the item, scans step one entry per cycle
   hlfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: table memory with registered read, carry entry and counters
   hlfa_dp #(
      .MAX_HOLES (MAX_HOLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_word  (rsp_word)
   );

   // a taken word always makes the sequencer busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while sequencer stays idle");

   // a dropped release only happens with the table at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == RSP_FULL) |-> rsp_word.holes_now == 7'(MAX_HOLES))
      else $error("full status with table below capacity");

   // a miss carries no grant and no remainder
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == RSP_MISS) |->
         (rsp_word.grant_offset == '0 && rsp_word.leftover_size == '0))
      else $error("miss status with grant data");

   // a remainder only comes from a completed allocate
   a_left_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.leftover_size != '0) |-> rsp_word.status == RSP_DONE)
      else $error("remainder reported on a failed word");

endmodule
`default_nettype wire

// ----- rtl/hlfa_dp.sv -----
// hlfa_dp: hole table memory, carry registers, scan counters and result register
`timescale 1ns / 1ps
`default_nettype none
module hlfa_dp import hlfa_pkg::*; #(
   parameter int MAX_HOLES = HLF_MAX_HOLES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_wdata,
   input  wire req_word_type req_word,
   input  wire dp_cmd_type   cmd,
   output dp_stat_type       stat,
   output rsp_word_type      rsp_word
);

   localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int CW = $clog2(MAX_HOLES + 1);

   logic [31:0] hole_off_mem  [MAX_HOLES];
   logic [31:0] hole_size_mem [MAX_HOLES];

   logic [1:0]    policy_ff, policy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] wr_ff, wr_in;
   logic          swapped_ff, swapped_in;
   logic          found_ff, found_in;
   logic [31:0]   car_off_ff, car_off_in;
   logic [31:0]   car_size_ff, car_size_in;
   logic [31:0]   rd_off_ff, rd_size_ff;
   req_word_type  req_ff, req_in;
   logic [1:0]    code_ff, code_in;
   logic [31:0]   grant_ff, grant_in;
   logic [31:0]   left_ff, left_in;
   logic [31:0]   acc_ff, acc_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic          we;
   logic [IW-1:0] wa, ra;
   logic [31:0]   wd_off, wd_size;
   logic [CW-1:0] cnt_m1;
   logic [CW:0]   idx_p1;
   logic [31:0]   req_size32;
   logic [32:0]   end_sum, mrg_sum, acc_sum;

   assign cnt_m1     = cnt_ff - 1'b1;
   assign idx_p1     = {{(CW + 1 - IW){1'b0}}, idx_ff} + 1'b1;
   assign req_size32 = {8'd0, req_ff.block_size};
   assign end_sum    = {1'b0, car_off_ff} + {1'b0, car_size_ff};
   assign mrg_sum    = {1'b0, car_size_ff} + {1'b0, rd_size_ff};
   assign acc_sum    = {1'b0, acc_ff} + {1'b0, rd_size_ff};

   always_comb begin
      policy_in   = policy_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      wr_in       = wr_ff;
      swapped_in  = swapped_ff;
      found_in    = found_ff;
      car_off_in  = car_off_ff;
      car_size_in = car_size_ff;
      req_in      = req_ff;
      code_in     = code_ff;
      grant_in    = grant_ff;
      left_in     = left_ff;
      acc_in      = acc_ff;
      rsp_in      = rsp_ff;
      we          = 1'b0;
      wa          = idx_ff;
      wd_off      = car_off_ff;
      wd_size     = car_size_ff;
      ra          = idx_ff + 1'b1;
      if (csr_we) begin
         policy_in = csr_wdata;
      end
      case (cmd.op)
         OP_LOAD: begin
            req_in   = req_word;
            code_in  = RSP_DONE;
            grant_in = '0;
            left_in  = '0;
         end
         OP_APPEND: begin
            we      = 1'b1;
            wa      = cnt_ff[IW-1:0];
            wd_off  = req_ff.block_offset;
            wd_size = req_size32;
            cnt_in  = cnt_ff + 1'b1;
         end
         OP_SET_FULL: code_in = RSP_FULL;
         OP_SET_MISS: code_in = RSP_MISS;
         OP_SORT_INIT: begin
            idx_in     = cnt_m1[IW-1:0];
            ra         = cnt_m1[IW-1:0];
            swapped_in = 1'b0;
         end
         OP_SORT_CAR: begin
            car_off_in  = rd_off_ff;
            car_size_in = rd_size_ff;
            ra          = idx_ff - 1'b1;
         end
         OP_SORT_CMP: begin
            // carry bubbles toward the front while it precedes its neighbor
            we = 1'b1;
            wa = idx_ff;
            if (precedes(policy_ff, car_size_ff, car_off_ff, rd_size_ff, rd_off_ff)) begin
               wd_off     = rd_off_ff;
               wd_size    = rd_size_ff;
               swapped_in = 1'b1;
            end else begin
               car_off_in  = rd_off_ff;
               car_size_in = rd_size_ff;
            end
            idx_in = idx_ff - 1'b1;
            ra     = idx_ff - 2'd2;
         end
         OP_SORT_LAST: begin
            we = 1'b1;
            wa = '0;
         end
         OP_MRG_INIT: begin
            idx_in = '0;
            wr_in  = '0;
            ra     = '0;
         end
         OP_MRG_CAR: begin
            car_off_in  = rd_off_ff;
            car_size_in = rd_size_ff;
            idx_in      = IW'(1);
            ra          = IW'(1);
         end
         OP_MRG_CMP: begin
            if (end_sum == {1'b0, rd_off_ff}) begin
               car_size_in = mrg_sum[32] ? 32'hFFFF_FFFF : mrg_sum[31:0];
            end else begin
               we          = 1'b1;
               wa          = wr_ff;
               wr_in       = wr_ff + 1'b1;
               car_off_in  = rd_off_ff;
               car_size_in = rd_size_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_MRG_LAST: begin
            we     = 1'b1;
            wa     = wr_ff;
            cnt_in = CW'({1'b0, wr_ff} + 1'b1);
         end
         OP_ALC_INIT: begin
            idx_in   = '0;
            found_in = 1'b0;
            ra       = '0;
         end
         OP_ALC_SCAN: begin
            // first fit is taken, entries behind it slide down one place
            if (!found_ff && (rd_size_ff >= req_size32)) begin
               found_in = 1'b1;
               grant_in = rd_off_ff;
               left_in  = rd_size_ff - req_size32;
            end else if (found_ff) begin
               we      = 1'b1;
               wa      = idx_ff - 1'b1;
               wd_off  = rd_off_ff;
               wd_size = rd_size_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_ALC_END: begin
            if (!found_ff) begin
               code_in = RSP_MISS;
            end else if (left_ff != '0) begin
               we      = 1'b1;
               wa      = cnt_m1[IW-1:0];
               wd_off  = grant_ff + req_size32;
               wd_size = left_ff;
            end else begin
               cnt_in = cnt_m1;
            end
         end
         OP_SUM_INIT: begin
            idx_in = '0;
            acc_in = '0;
            ra     = '0;
         end
         OP_SUM_SCAN: begin
            acc_in = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
            idx_in = idx_ff + 1'b1;
         end
         OP_OUT: begin
            rsp_in.status        = code_ff;
            rsp_in.grant_offset  = grant_ff;
            rsp_in.leftover_size = left_ff;
            rsp_in.holes_now     = 7'(cnt_ff);
            rsp_in.free_space    = acc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         hole_off_mem[wa]  <= wd_off;
         hole_size_mem[wa] <= wd_size;
      end
      rd_off_ff  <= hole_off_mem[ra];
      rd_size_ff <= hole_size_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_BEST;
         cnt_ff    <= '0;
      end else begin
         policy_ff <= policy_in;
         cnt_ff    <= cnt_in;
      end
      idx_ff      <= idx_in;
      wr_ff       <= wr_in;
      swapped_ff  <= swapped_in;
      found_ff    <= found_in;
      car_off_ff  <= car_off_in;
      car_size_ff <= car_size_in;
      req_ff      <= req_in;
      code_ff     <= code_in;
      grant_ff    <= grant_in;
      left_ff     <= left_in;
      acc_ff      <= acc_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      stat.func      = req_ff.func;
      stat.full      = cnt_ff == CW'(MAX_HOLES);
      stat.cnt_zero  = cnt_ff == '0;
      stat.idx_one   = idx_ff == IW'(1);
      stat.idx_last  = idx_p1 == {1'b0, cnt_ff};
      stat.swapped   = swapped_ff;
      stat.pol_sort  = policy_ff != POL_NONE;
      stat.pol_merge = policy_ff == POL_ADDR;
   end

   assign rsp_word = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/hlfa_ctrl.sv -----
// hlfa_ctrl: sequencer for append, sort passes, merge, allocate scan and sum
`timescale 1ns / 1ps
`default_nettype none
module hlfa_ctrl import hlfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISP      = 4'd1;
   localparam logic [3:0] S_SORT_INIT = 4'd2;
   localparam logic [3:0] S_SORT_CAR  = 4'd3;
   localparam logic [3:0] S_SORT_CMP  = 4'd4;
   localparam logic [3:0] S_SORT_LAST = 4'd5;
   localparam logic [3:0] S_MRG_INIT  = 4'd6;
   localparam logic [3:0] S_MRG_CAR   = 4'd7;
   localparam logic [3:0] S_MRG_CMP   = 4'd8;
   localparam logic [3:0] S_MRG_LAST  = 4'd9;
   localparam logic [3:0] S_ALC_INIT  = 4'd10;
   localparam logic [3:0] S_ALC_SCAN  = 4'd11;
   localparam logic [3:0] S_ALC_END   = 4'd12;
   localparam logic [3:0] S_SUM_INIT  = 4'd13;
   localparam logic [3:0] S_SUM_SCAN  = 4'd14;
   localparam logic [3:0] S_DONE      = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.func == FUNC_RELEASE) begin
               if (stat.full) begin
                  cmd.op   = OP_SET_FULL;
                  state_in = S_SUM_INIT;
               end else begin
                  cmd.op   = OP_APPEND;
                  state_in = (!stat.pol_sort || stat.cnt_zero) ? S_SUM_INIT : S_SORT_INIT;
               end
            end else if (stat.cnt_zero) begin
               cmd.op   = OP_SET_MISS;
               state_in = S_SUM_INIT;
            end else begin
               state_in = S_ALC_INIT;
            end
         end
         S_SORT_INIT: begin
            cmd.op   = OP_SORT_INIT;
            state_in = S_SORT_CAR;
         end
         S_SORT_CAR: begin
            cmd.op   = OP_SORT_CAR;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            cmd.op = OP_SORT_CMP;
            if (stat.idx_one) begin
               state_in = S_SORT_LAST;
            end
         end
         S_SORT_LAST: begin
            cmd.op = OP_SORT_LAST;
            if (stat.swapped) begin
               state_in = S_SORT_INIT;
            end else begin
               state_in = stat.pol_merge ? S_MRG_INIT : S_SUM_INIT;
            end
         end
         S_MRG_INIT: begin
            cmd.op   = OP_MRG_INIT;
            state_in = S_MRG_CAR;
         end
         S_MRG_CAR: begin
            cmd.op   = OP_MRG_CAR;
            state_in = S_MRG_CMP;
         end
         S_MRG_CMP: begin
            cmd.op = OP_MRG_CMP;
            if (stat.idx_last) begin
               state_in = S_MRG_LAST;
            end
         end
         S_MRG_LAST: begin
            cmd.op   = OP_MRG_LAST;
            state_in = S_SUM_INIT;
         end
         S_ALC_INIT: begin
            cmd.op   = OP_ALC_INIT;
            state_in = S_ALC_SCAN;
         end
         S_ALC_SCAN: begin
            cmd.op = OP_ALC_SCAN;
            if (stat.idx_last) begin
               state_in = S_ALC_END;
            end
         end
         S_ALC_END: begin
            cmd.op   = OP_ALC_END;
            state_in = S_SUM_INIT;
         end
         S_SUM_INIT: begin
            cmd.op   = OP_SUM_INIT;
            state_in = stat.cnt_zero ? S_DONE : S_SUM_SCAN;
         end
         S_SUM_SCAN: begin
            cmd.op = OP_SUM_SCAN;
            if (stat.idx_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- bench/tb_hole_list_fit_allocator.sv -----
// testbench for hole_list_fit_allocator: directed and random words checked against a hole table predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_hole_list_fit_allocator;
   import hlfa_pkg::*;

   // predictor of the hole table plus the queue of expected result words
   class alloc_scoreboard;
      logic [31:0]  hole_size [HLF_MAX_HOLES];
      logic [31:0]  hole_off [HLF_MAX_HOLES];
      int           holes;
      logic [1:0]   policy;
      rsp_word_type expected_q [$];
      int           errors;

      function new();
         holes = 0;
         policy = POL_BEST;
         errors = 0;
      endfunction

      // hole a stands strictly ahead of hole b under the current policy
      function bit ahead_of(logic [31:0] sa, logic [31:0] oa, logic [31:0] sb,
                            logic [31:0] ob);
         if (policy == POL_ADDR) return (oa != ob) ? (oa < ob) : (sa < sb);
         if (sa != sb) return (policy == POL_BEST) ? (sa < sb) : (sa > sb);
         return oa < ob;
      endfunction

      function void remove_at(int idx);
         for (int k = idx; k + 1 < holes; k++) begin
            hole_size[k] = hole_size[k+1];
            hole_off[k] = hole_off[k+1];
         end
         if (holes > 0) holes--;
      endfunction

      function void reorder();
         logic [31:0] s, o;
         logic [32:0] merged;
         int j;
         bit again;
         if (policy == POL_NONE) return;
         for (int i = 1; i < holes; i++) begin
            s = hole_size[i];
            o = hole_off[i];
            j = i;
            while (j > 0 && ahead_of(s, o, hole_size[j-1], hole_off[j-1])) begin
               hole_size[j] = hole_size[j-1];
               hole_off[j] = hole_off[j-1];
               j--;
            end
            hole_size[j] = s;
            hole_off[j] = o;
         end
         if (policy != POL_ADDR) return;
         // merge the first touching pair until none is left
         again = 1;
         while (again) begin
            again = 0;
            for (int c = 0; c + 1 < holes && !again; c++) begin
               if ({1'b0, hole_off[c]} + {1'b0, hole_size[c]} == {1'b0, hole_off[c+1]}) begin
                  merged = {1'b0, hole_size[c]} + {1'b0, hole_size[c+1]};
                  hole_size[c] = merged[32] ? 32'hFFFF_FFFF : merged[31:0];
                  remove_at(c + 1);
                  again = 1;
               end
            end
         end
      endfunction

      // work out the result of one accepted word and queue it
      function void note_word(req_word_type w);
         rsp_word_type r;
         logic [31:0] need;
         logic [63:0] sum;
         int p;
         r = '0;
         need = {8'd0, w.block_size};
         if (w.func == FUNC_RELEASE) begin
            if (holes >= HLF_MAX_HOLES) r.status = RSP_FULL;
            else begin
               hole_off[holes] = w.block_offset;
               hole_size[holes] = need;
               holes++;
               reorder();
            end
         end else begin
            p = 0;
            while (p < holes && hole_size[p] < need) p++;
            if (p >= holes) r.status = RSP_MISS;
            else begin
               r.status = RSP_DONE;
               r.grant_offset = hole_off[p];
               r.leftover_size = hole_size[p] - need;
               remove_at(p);
               if (r.leftover_size != 0) begin
                  hole_off[holes] = r.grant_offset + need;
                  hole_size[holes] = r.leftover_size;
                  holes++;
               end
            end
         end
         sum = 0;
         for (int i = 0; i < holes; i++) sum += hole_size[i];
         r.free_space = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         r.holes_now = holes[6:0];
         expected_q.push_back(r);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected st=%0d grant=%h left=%h holes=%0d free=%h",
                     $time, want.status, want.grant_offset, want.leftover_size,
                     want.holes_now, want.free_space);
            $display("%0t:          actual   st=%0d grant=%h left=%h holes=%0d free=%h",
                     $time, got.status, got.grant_offset, got.leftover_size,
                     got.holes_now, got.free_space);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_we;
   logic [1:0]   csr_wdata;

   alloc_scoreboard sb;
   int accepted;
   int burst_left;
   bit held_off;
   bit stim_done;

   hole_list_fit_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // offer one word and hold it until accepted; bursts separated by random gaps
   task automatic send_word(logic fn, logic [31:0] off, logic [23:0] size);
      req_word_type w;
      w.func = fn;
      w.block_offset = off;
      w.block_size = size;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      accepted++;
      burst_left--;
   endtask

   // policy writes only once the block has drained
   task automatic write_policy(logic [1:0] pol);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= pol;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.policy = pol;
      burst_left = 0;
   endtask

   // random word; mostly offsets on a 16 grid so holes touch and merge
   task automatic send_random(int release_pct);
      logic [31:0] off;
      logic [23:0] size;
      int pick;
      if ($urandom_range(0, 99) < release_pct) begin
         if ($urandom_range(0, 3) != 0) begin
            off = $urandom_range(0, 63) * 16;
            size = 24'($urandom_range(1, 4) * 16);
         end else begin
            off = $urandom;
            size = 24'($urandom);
         end
         send_word(FUNC_RELEASE, off, size);
      end else begin
         pick = $urandom_range(0, 19);
         if (pick == 0) size = 24'd0;
         else if (pick < 3) size = 24'($urandom);
         else size = 24'($urandom_range(1, 64));
         send_word(FUNC_ALLOCATE, $urandom, size);
      end
   endtask

   // empties the table by allocating the head hole, up to the widest request
   task automatic drain_table();
      int guard;
      logic [23:0] take;
      guard = 0;
      while (sb.holes > 0 && guard < 400) begin
         take = (sb.hole_size[0] > 32'h00FF_FFFF) ? 24'hFF_FFFF : sb.hole_size[0][23:0];
         send_word(FUNC_ALLOCATE, 32'd0, take);
         guard++;
      end
   endtask

   // stimulus
   initial begin
      logic [1:0] pol_seq [8];
      pol_seq = '{POL_BEST, POL_WORST, POL_ADDR, POL_NONE, POL_BEST, POL_ADDR,
                  POL_WORST, POL_ADDR};
      sb = new();
      accepted = 0;
      burst_left = 0;
      stim_done = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      csr_we <= 1'b0;
      csr_wdata <= POL_BEST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_policy(POL_BEST);

      // best fit corner cases
      send_word(FUNC_ALLOCATE, 32'd0, 24'd5);                  // empty table, nothing fits
      send_word(FUNC_RELEASE, 32'hFFFF_FF00, 24'h300);
      send_word(FUNC_ALLOCATE, 32'd0, 24'h200);                // remainder offset wraps
      send_word(FUNC_ALLOCATE, 32'd0, 24'd0);                  // zero request re-appends
      send_word(FUNC_RELEASE, 32'd0, 24'hFF_FFFF);
      send_word(FUNC_RELEASE, 32'hFFFF_FFFF, 24'd1);
      send_word(FUNC_RELEASE, 32'h0000_1234, 24'd0);           // zero size hole kept
      send_word(FUNC_ALLOCATE, 32'hFFFF_FFFF, 24'hFF_FFFF);
      send_word(FUNC_ALLOCATE, 32'd0, 24'hFF_FFFF);
      send_word(FUNC_ALLOCATE, 32'd0, 24'd1);
      // worst fit
      write_policy(POL_WORST);
      send_word(FUNC_RELEASE, 32'h40, 24'h10);
      send_word(FUNC_RELEASE, 32'h80, 24'h10);
      send_word(FUNC_ALLOCATE, 32'd0, 24'h8);
      // address order: touching holes, equal offsets
      write_policy(POL_ADDR);
      send_word(FUNC_RELEASE, 32'h1000, 24'h10);
      send_word(FUNC_RELEASE, 32'h1010, 24'h10);
      send_word(FUNC_RELEASE, 32'h1000, 24'h4);
      send_word(FUNC_RELEASE, 32'h0FF0, 24'h10);
      send_word(FUNC_ALLOCATE, 32'd0, 24'h4);
      // policy three leaves the table unsorted
      write_policy(POL_NONE);
      send_word(FUNC_RELEASE, 32'h5, 24'h7);
      send_word(FUNC_ALLOCATE, 32'd0, 24'h3);

      // random phases; even ones fill the table up to full
      for (int ph = 0; ph < 8; ph++) begin
         write_policy(pol_seq[ph]);
         for (int n = 0; n < 200; n++) send_random((ph % 2 == 0) ? 75 : 35);
         if (ph == 3) begin
            // one contiguous run that merges into a single saturated hole
            drain_table();
            write_policy(POL_ADDR);
            for (int k = 0; k < 256; k++) send_word(FUNC_RELEASE, k * 32'h00FF_FFFF, 24'hFF_FFFF);
            send_word(FUNC_RELEASE, 32'hFFFF_FF00, 24'hFF_FFFF);
            send_word(FUNC_ALLOCATE, 32'd0, 24'hFF_FFFF);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // receiver: stall pattern of its own plus one long hold-off
   initial begin
      int hold;
      int mode_left;
      bit choppy;
      rsp_stall <= 1'b0;
      hold = 0;
      held_off = 0;
      mode_left = 0;
      choppy = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_word);
         if (!held_off && accepted >= 400) begin
            held_off = 1;
            hold = 3000;
         end
         if (mode_left <= 0) begin
            choppy = 1'($urandom_range(0, 1));
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= choppy ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #400ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
